/* design/kts_pkg.sv */
// ----------------------------------------------------------------------------
// kts_pkg: shared types and constants for the topological sorter
// Vertex and count widths plus default sizing for the vertex and edge stores.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int VTX_W = 6;   // vertex index width on the channels
  localparam int CNT_W = 7;   // vertex_count register width

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_EDGES    = 256;

  localparam logic [CNT_W-1:0] VCOUNT_RST = 7'd64;

  typedef logic [VTX_W-1:0] vertex_t;
  typedef logic [CNT_W-1:0] vcount_t;

endpackage

/* design/kts_edge_if.sv */
// ----------------------------------------------------------------------------
// kts_edge_if: edge input channel
// Valid/ready channel carrying one directed edge or a terminator per transfer.
// ----------------------------------------------------------------------------
interface kts_edge_if import kts_pkg::*; ();

  logic    valid;
  logic    ready;
  vertex_t edge_source;
  vertex_t edge_target;
  logic    carries_edge;
  logic    final_edge;

  modport source (
    output valid, edge_source, edge_target, carries_edge, final_edge,
    input  ready
  );

  modport sink (
    input  valid, edge_source, edge_target, carries_edge, final_edge,
    output ready
  );

endinterface

/* design/kts_result_if.sv */
// ----------------------------------------------------------------------------
// kts_result_if: sorted vertex output channel
// Valid/ready channel carrying one vertex of the sort order per transfer.
// ----------------------------------------------------------------------------
interface kts_result_if import kts_pkg::*; ();

  logic    valid;
  logic    ready;
  vertex_t sorted_vertex;
  logic    vertex_valid;
  logic    run_end;
  logic    acyclic;
  logic    edge_dropped;

  modport source (
    output valid, sorted_vertex, vertex_valid, run_end, acyclic, edge_dropped,
    input  ready
  );

  modport sink (
    input  valid, sorted_vertex, vertex_valid, run_end, acyclic, edge_dropped,
    output ready
  );

endinterface

/* design/kahn_topological_sort.sv */
// Edge load: a stored edge takes S_IDLE and S_LOAD, a dropped or empty item S_IDLE only
//   (tail and in-degree read-modify-write through memories with registered reads).
// Sort: S_SEED seeds from the in-degree valid bits; per vertex S_POP, S_HEAD, S_WALK,
//   S_EDGE1/S_EDGE2 per outgoing edge (link walk + in-degree update), S_EMIT, plus stalls.
// Reset: synchronous active-low rst_n clears control state, counters and the per-vertex
//   valid bits of list_head and in_degree; memories have no clearing pass.
// ----------------------------------------------------------------------------
// kahn_topological_sort: Kahn's algorithm over a streamed edge list
// Stores per-source linked edge lists and in-degrees in on-chip memories and
// emits the vertices in topological order when the final item arrives.
// ----------------------------------------------------------------------------
module kahn_topological_sort import kts_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
  input  logic             clk,
  input  logic             rst_n,
  kts_edge_if.sink         in_edge,
  kts_result_if.source     out_result,
  input  logic             cfg_we,
  input  vcount_t          cfg_wdata
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int QW  = $clog2(MAX_VERTICES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int LW  = $clog2(MAX_EDGES + 1);

  localparam logic [LW-1:0]    NULL_LINK = LW'(MAX_EDGES);
  localparam logic [CNT_W-1:0] MAXV_C    = CNT_W'(MAX_VERTICES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_SEED  = 4'd2;
  localparam logic [3:0] S_POP   = 4'd3;
  localparam logic [3:0] S_HEAD  = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_EDGE1 = 4'd6;
  localparam logic [3:0] S_EDGE2 = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  // memories
  vertex_t         dest_mem [MAX_EDGES];
  logic [LW-1:0]   link_mem [MAX_EDGES];
  logic [LW-1:0]   head_mem [MAX_VERTICES];
  logic [LW-1:0]   tail_mem [MAX_VERTICES];
  logic [LW-1:0]   deg_mem  [MAX_VERTICES];
  vertex_t         fifo_mem [MAX_VERTICES];

  logic            dest_we, link_we, head_we, tail_we, deg_we, fifo_we;
  logic [EAW-1:0]  dest_wa, link_wa, edge_ra;
  vertex_t         dest_wd;
  logic [LW-1:0]   link_wd, head_wd, tail_wd, deg_wd;
  logic [VW-1:0]   head_wa, head_ra, tail_wa, tail_ra, deg_wa, deg_ra, fifo_wa, fifo_ra;
  vertex_t         fifo_wd;
  vertex_t         dest_q, fifo_q;
  logic [LW-1:0]   link_q, head_q, tail_q, deg_q;

  // control registers
  logic [3:0]              state_r, state_nxt;
  vcount_t                 vertex_count_r;
  logic [LW-1:0]           edges_r, edges_nxt;
  logic                    drop_r, drop_nxt;
  logic [MAX_VERTICES-1:0] head_vld_r, head_vld_nxt;
  logic [MAX_VERTICES-1:0] deg_vld_r, deg_vld_nxt;
  logic [QW-1:0]           wr_r, wr_nxt, rd_r, rd_nxt;
  vcount_t                 seed_i_r, seed_i_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // payload registers
  vertex_t                 src_r, src_nxt, dst_r, dst_nxt, v_r, v_nxt, d_r, d_nxt;
  logic                    fin_r, fin_nxt, hv_r, hv_nxt;
  logic [LW-1:0]           e_r, e_nxt;
  vertex_t                 out_vertex_r, out_vertex_nxt;
  logic                    out_vvalid_r, out_vvalid_nxt;
  logic                    out_end_r, out_end_nxt;
  logic                    out_acyc_r, out_acyc_nxt;
  logic                    out_drop_r, out_drop_nxt;

  vcount_t                 n_eff;
  logic                    in_xfer, keep;
  logic [LW-1:0]           walk_e;
  logic [LW-1:0]           load_deg, walk_deg;
  logic                    dec_ok, emit_go, emit_last;

  assign n_eff     = (vertex_count_r > MAXV_C) ? MAXV_C : vertex_count_r;
  assign in_xfer   = in_edge.valid && in_edge.ready;
  assign keep      = in_edge.carries_edge
                     && ({1'b0, in_edge.edge_source} < n_eff)
                     && ({1'b0, in_edge.edge_target} < n_eff)
                     && (edges_r < NULL_LINK);
  assign walk_e    = (state_r == S_WALK) ? (hv_r ? head_q : NULL_LINK) : e_r;
  assign load_deg  = deg_vld_r[dst_r[VW-1:0]] ? deg_q : '0;
  assign walk_deg  = deg_vld_r[d_r[VW-1:0]] ? deg_q : '0;
  // stale stored edges into vertices at or above the current count are skipped
  assign dec_ok    = ({1'b0, d_r} < n_eff) && (walk_deg != '0);
  assign emit_go   = !out_valid_r || out_result.ready;
  assign emit_last = (rd_r == wr_r);

  assign in_edge.ready = (state_r == S_IDLE);

  assign out_result.valid         = out_valid_r;
  assign out_result.sorted_vertex = out_vertex_r;
  assign out_result.vertex_valid  = out_vvalid_r;
  assign out_result.run_end       = out_end_r;
  assign out_result.acyclic       = out_acyc_r;
  assign out_result.edge_dropped  = out_drop_r;

  always_comb begin
    state_nxt      = state_r;
    edges_nxt      = edges_r;
    drop_nxt       = drop_r;
    head_vld_nxt   = head_vld_r;
    deg_vld_nxt    = deg_vld_r;
    wr_nxt         = wr_r;
    rd_nxt         = rd_r;
    seed_i_nxt     = seed_i_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    fin_nxt        = fin_r;
    hv_nxt         = hv_r;
    v_nxt          = v_r;
    d_nxt          = d_r;
    e_nxt          = e_r;
    out_vertex_nxt = out_vertex_r;
    out_vvalid_nxt = out_vvalid_r;
    out_end_nxt    = out_end_r;
    out_acyc_nxt   = out_acyc_r;
    out_drop_nxt   = out_drop_r;
    out_valid_nxt  = out_result.ready ? 1'b0 : out_valid_r;

    dest_we = 1'b0; dest_wa = edges_r[EAW-1:0]; dest_wd = in_edge.edge_target;
    link_we = 1'b0; link_wa = edges_r[EAW-1:0]; link_wd = NULL_LINK;
    head_we = 1'b0; head_wa = in_edge.edge_source[VW-1:0]; head_wd = edges_r;
    tail_we = 1'b0; tail_wa = src_r[VW-1:0];               tail_wd = edges_r;
    deg_we  = 1'b0; deg_wa  = dst_r[VW-1:0];               deg_wd  = load_deg + 1'b1;
    fifo_we = 1'b0; fifo_wa = wr_r[VW-1:0];                fifo_wd = d_r;
    edge_ra = walk_e[EAW-1:0];
    head_ra = fifo_q[VW-1:0];
    tail_ra = in_edge.edge_source[VW-1:0];
    deg_ra  = in_edge.edge_target[VW-1:0];
    fifo_ra = rd_r[VW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          src_nxt = in_edge.edge_source;
          dst_nxt = in_edge.edge_target;
          fin_nxt = in_edge.final_edge;
          hv_nxt  = head_vld_r[in_edge.edge_source[VW-1:0]];
          if (in_edge.carries_edge && !keep) begin
            drop_nxt = 1'b1;
          end
          if (keep) begin
            dest_we = 1'b1;
            link_we = 1'b1;
            if (!head_vld_r[in_edge.edge_source[VW-1:0]]) begin
              head_we = 1'b1;
              head_vld_nxt[in_edge.edge_source[VW-1:0]] = 1'b1;
            end
            state_nxt = S_LOAD;
          end else if (in_edge.final_edge) begin
            wr_nxt     = '0;
            rd_nxt     = '0;
            seed_i_nxt = '0;
            state_nxt  = S_SEED;
          end
        end
      end
      S_LOAD: begin
        // tail and in-degree read data are back: finish the append
        tail_we = 1'b1;
        if (hv_r) begin
          link_we = 1'b1;
          link_wa = tail_q[EAW-1:0];
          link_wd = edges_r;
        end
        deg_we = 1'b1;
        deg_vld_nxt[dst_r[VW-1:0]] = 1'b1;
        edges_nxt = edges_r + 1'b1;
        if (fin_r) begin
          wr_nxt     = '0;
          rd_nxt     = '0;
          seed_i_nxt = '0;
          state_nxt  = S_SEED;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SEED: begin
        // before the walk, in-degree is zero exactly where no edge was counted
        if (seed_i_r < n_eff) begin
          if (!deg_vld_r[seed_i_r[VW-1:0]]) begin
            fifo_we = 1'b1;
            fifo_wd = seed_i_r[VTX_W-1:0];
            wr_nxt  = wr_r + 1'b1;
          end
          seed_i_nxt = seed_i_r + 1'b1;
        end else begin
          state_nxt = (wr_r == '0) ? S_EMIT : S_POP;
        end
      end
      S_POP: begin
        rd_nxt    = rd_r + 1'b1;
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        v_nxt     = fifo_q;
        hv_nxt    = head_vld_r[fifo_q[VW-1:0]];
        state_nxt = S_WALK;
      end
      S_WALK: begin
        state_nxt = (walk_e == NULL_LINK) ? S_EMIT : S_EDGE1;
      end
      S_EDGE1: begin
        d_nxt     = dest_q;
        e_nxt     = link_q;
        deg_ra    = dest_q[VW-1:0];
        state_nxt = S_EDGE2;
      end
      S_EDGE2: begin
        if (dec_ok) begin
          deg_we = 1'b1;
          deg_wa = d_r[VW-1:0];
          deg_wd = walk_deg - 1'b1;
          if (walk_deg == LW'(1)) begin
            fifo_we = 1'b1;
            wr_nxt  = wr_r + 1'b1;
          end
        end
        state_nxt = (walk_e == NULL_LINK) ? S_EMIT : S_EDGE1;
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt  = 1'b1;
          out_vvalid_nxt = (wr_r != '0);
          out_vertex_nxt = (wr_r != '0) ? v_r : '0;
          out_end_nxt    = emit_last;
          out_acyc_nxt   = emit_last && (CNT_W'(wr_r) == n_eff);
          out_drop_nxt   = drop_r;
          if (emit_last) begin
            head_vld_nxt = '0;
            deg_vld_nxt  = '0;
            edges_nxt    = '0;
            drop_nxt     = 1'b0;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_POP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      vertex_count_r <= VCOUNT_RST;
      edges_r        <= '0;
      drop_r         <= 1'b0;
      head_vld_r     <= '0;
      deg_vld_r      <= '0;
      wr_r           <= '0;
      rd_r           <= '0;
      seed_i_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      edges_r     <= edges_nxt;
      drop_r      <= drop_nxt;
      head_vld_r  <= head_vld_nxt;
      deg_vld_r   <= deg_vld_nxt;
      wr_r        <= wr_nxt;
      rd_r        <= rd_nxt;
      seed_i_r    <= seed_i_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        vertex_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    fin_r        <= fin_nxt;
    hv_r         <= hv_nxt;
    v_r          <= v_nxt;
    d_r          <= d_nxt;
    e_r          <= e_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_vvalid_r <= out_vvalid_nxt;
    out_end_r    <= out_end_nxt;
    out_acyc_r   <= out_acyc_nxt;
    out_drop_r   <= out_drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (dest_we) begin
      dest_mem[dest_wa] <= dest_wd;
    end
    dest_q <= dest_mem[edge_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_q <= link_mem[edge_ra];
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (tail_we) begin
      tail_mem[tail_wa] <= tail_wd;
    end
    tail_q <= tail_mem[tail_ra];
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
    end
    deg_q <= deg_mem[deg_ra];
  end

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_wa] <= fifo_wd;
    end
    fifo_q <= fifo_mem[fifo_ra];
  end

  // assertions
  a_fifo_order: assert property (@(posedge clk) disable iff (!rst_n)
    rd_r <= wr_r)
    else $error("ready queue read pointer passed write pointer");

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_LOAD) |-> (CNT_W'(wr_r) <= n_eff))
    else $error("more vertices queued than the graph holds");

  a_edge_cap: assert property (@(posedge clk) disable iff (!rst_n)
    edges_r <= NULL_LINK)
    else $error("edge count beyond store capacity");

  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && emit_go && emit_last) |=>
      (state_r == S_IDLE && head_vld_r == '0 && deg_vld_r == '0 && edges_r == '0))
    else $error("graph store not cleared after the last transfer of a run");

endmodule
